/* src/complex_rect_to_polar_core_defines.svh */
// Assertion helpers shared by the polar converter files.
`ifndef COMPLEX_RECT_TO_POLAR_CORE_DEFINES_SVH
`define COMPLEX_RECT_TO_POLAR_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CRP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CRP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/crp_pkg.sv */
package crp_pkg;

    localparam int DEF_ITERATIONS = 16;
    localparam int DEF_DATA_WIDTH = 16;

    // extra fraction bits carried through the rotations
    localparam int GUARD      = 8;
    localparam int TABLE_LEN  = 24;

    // angle accumulator, degrees in Q20
    localparam int ZW         = 30;
    localparam logic signed [ZW-1:0] HALF_TURN_Q20 = ZW'(188743680);

    // gain 0.6072529350 * 2^22
    localparam int GAIN_W     = 22;
    localparam logic [GAIN_W-1:0] GAIN_Q = GAIN_W'(2547003);
    localparam int GAIN_SHIFT = 30;
    localparam int LO_W       = 16;

    // output phase, degrees in Q7
    localparam int PHASE_W    = 16;
    localparam int PHASE_MAX  = 23040;
    localparam int PH_SHIFT   = 13;
    localparam int PH_RND     = 4096;

    // arctan(2^-i) in degrees, Q20
    localparam logic signed [ZW-1:0] ATAN_Q20 [TABLE_LEN] = '{
        ZW'(47185920), ZW'(27855475), ZW'(14718068), ZW'(7471121),
        ZW'(3750058),  ZW'(1876857),  ZW'(938658),   ZW'(469357),
        ZW'(234682),   ZW'(117342),   ZW'(58671),    ZW'(29335),
        ZW'(14668),    ZW'(7334),     ZW'(3667),     ZW'(1833),
        ZW'(917),      ZW'(458),      ZW'(229),      ZW'(115),
        ZW'(57),       ZW'(29),       ZW'(14),       ZW'(7)
    };

    typedef struct packed {
        logic byp;   // imaginary part zero: rotations skipped
        logic neg;   // real part negative
    } t_flags;

endpackage

/* src/crp_pre.sv */
module crp_pre import crp_pkg::*; #(
    parameter int DATA_WIDTH = DEF_DATA_WIDTH,
    parameter int XW         = DEF_DATA_WIDTH + GUARD + 2
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic signed [DATA_WIDTH-1:0] i_re,
    input  logic signed [DATA_WIDTH-1:0] i_im,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic signed [XW-1:0]        o_x,
    output logic signed [XW-1:0]        o_y,
    output logic signed [ZW-1:0]        o_z,
    output t_flags                      o_flags
);

    logic                 r_valid;
    logic signed [XW-1:0] r_x, r_y, n_x, n_y;
    logic signed [ZW-1:0] r_z, n_z;
    t_flags               r_flags, n_flags;
    logic signed [XW-1:0] x0, y0;

    assign o_ready = !r_valid || i_ready;

    always_comb begin
        x0 = XW'(i_re) <<< GUARD;
        y0 = XW'(i_im) <<< GUARD;
        n_flags.byp = (i_im == '0);
        n_flags.neg = i_re[DATA_WIDTH-1];
        n_z = '0;
        if (n_flags.neg) begin
            // left half plane: turn by 180 degrees first
            n_x = -x0;
            n_y = -y0;
            if (!n_flags.byp) begin
                n_z = i_im[DATA_WIDTH-1] ? -HALF_TURN_Q20 : HALF_TURN_Q20;
            end
        end else begin
            n_x = x0;
            n_y = y0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_x     <= n_x;
            r_y     <= n_y;
            r_z     <= n_z;
            r_flags <= n_flags;
        end
    end

    assign o_valid = r_valid;
    assign o_x     = r_x;
    assign o_y     = r_y;
    assign o_z     = r_z;
    assign o_flags = r_flags;

endmodule

/* src/crp_cell.sv */
module crp_cell import crp_pkg::*; #(
    parameter int XW    = DEF_DATA_WIDTH + GUARD + 2,
    parameter int STAGE = 0
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic signed [XW-1:0] i_x,
    input  logic signed [XW-1:0] i_y,
    input  logic signed [ZW-1:0] i_z,
    input  t_flags               i_flags,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic signed [XW-1:0] o_x,
    output logic signed [XW-1:0] o_y,
    output logic signed [ZW-1:0] o_z,
    output t_flags               o_flags
);

    `include "complex_rect_to_polar_core_defines.svh"

    logic                 r_valid;
    logic signed [XW-1:0] r_x, r_y, n_x, n_y, dx, dy;
    logic signed [ZW-1:0] r_z, n_z;
    t_flags               r_flags;

    assign o_ready = !r_valid || i_ready;

    // one micro-rotation toward y = 0 (bypassed items pass unchanged); floor shifts
    always_comb begin
        dx = i_y >>> STAGE;
        dy = i_x >>> STAGE;
        if (i_flags.byp) begin
            n_x = i_x;
            n_y = i_y;
            n_z = i_z;
        end else if (!i_y[XW-1]) begin
            n_x = i_x + dx;
            n_y = i_y - dy;
            n_z = i_z + ATAN_Q20[STAGE];
        end else begin
            n_x = i_x - dx;
            n_y = i_y + dy;
            n_z = i_z - ATAN_Q20[STAGE];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_x     <= n_x;
            r_y     <= n_y;
            r_z     <= n_z;
            r_flags <= i_flags;
        end
    end

    assign o_valid = r_valid;
    assign o_x     = r_x;
    assign o_y     = r_y;
    assign o_z     = r_z;
    assign o_flags = r_flags;

    `CRP_ASSERT_NEXT(a_bypass_holds, i_clk, i_rst_n, o_ready && i_valid && i_flags.byp, r_x == $past(i_x) && r_z == $past(i_z), "bypassed item changed in cell")

endmodule

/* src/crp_post.sv */
module crp_post import crp_pkg::*; #(
    parameter int DATA_WIDTH = DEF_DATA_WIDTH,
    parameter int XW         = DEF_DATA_WIDTH + GUARD + 2
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic signed [XW-1:0]  i_x,
    input  logic signed [ZW-1:0]  i_z,
    input  t_flags                i_flags,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [DATA_WIDTH-1:0] o_mag,
    output logic signed [PHASE_W-1:0] o_phase
);

    `include "complex_rect_to_polar_core_defines.svh"

    localparam int XUW = XW - 1;          // x clamped at zero
    localparam int HW  = XUW - LO_W;      // upper slice of x
    localparam int PLW = LO_W + GAIN_W;
    localparam int PHW = HW + GAIN_W;
    localparam int PW  = XUW + GAIN_W;    // full product width

    localparam logic signed [ZW:0] PH_MAX_S = (ZW+1)'(PHASE_MAX);
    localparam logic signed [ZW:0] PH_MIN_S = -((ZW+1)'(PHASE_MAX));

    // stage 1: split gain product, phase rounding and clamping
    logic                        r1_valid, r1_ready;
    logic [PLW-1:0]              r1_plo, n_plo;
    logic [PHW-1:0]              r1_phi, n_phi;
    logic [DATA_WIDTH-1:0]       r1_bmag;
    logic                        r1_byp;
    logic signed [PHASE_W-1:0]   r1_ph, n_ph;
    logic [XUW-1:0]              xc;
    logic signed [ZW:0]          zr, zs;

    // stage 2: sum, round, saturate
    logic                        r2_valid;
    logic [DATA_WIDTH-1:0]       r2_mag, n_mag;
    logic signed [PHASE_W-1:0]   r2_ph;
    logic [PW:0]                 sum;

    assign r1_ready = !r2_valid || i_ready;
    assign o_ready  = !r1_valid || r1_ready;

    always_comb begin
        xc    = i_x[XW-1] ? '0 : i_x[XUW-1:0];
        n_plo = PLW'(xc[LO_W-1:0]) * PLW'(GAIN_Q);
        n_phi = PHW'(xc[XUW-1:LO_W]) * PHW'(GAIN_Q);
        zr    = (ZW+1)'(i_z) + (ZW+1)'(PH_RND);
        zs    = zr >>> PH_SHIFT;
        if (i_flags.byp) begin
            n_ph = i_flags.neg ? PHASE_W'(PHASE_MAX) : '0;
        end else if (zs > PH_MAX_S) begin
            n_ph = PHASE_W'(PHASE_MAX);
        end else if (zs < PH_MIN_S) begin
            n_ph = -(PHASE_W'(PHASE_MAX));
        end else begin
            n_ph = zs[PHASE_W-1:0];
        end
    end

    always_comb begin
        sum = (PW+1)'({r1_phi, {LO_W{1'b0}}}) + (PW+1)'(r1_plo)
            + ((PW+1)'(1) << (GAIN_SHIFT - 1));
        if (r1_byp) begin
            n_mag = r1_bmag;
        end else if (|sum[PW:GAIN_SHIFT+DATA_WIDTH]) begin
            n_mag = '1;
        end else begin
            n_mag = sum[GAIN_SHIFT+DATA_WIDTH-1:GAIN_SHIFT];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
        end else begin
            if (o_ready) begin
                r1_valid <= i_valid;
            end
            if (r1_ready) begin
                r2_valid <= r1_valid;
            end
        end
        if (o_ready && i_valid) begin
            r1_plo  <= n_plo;
            r1_phi  <= n_phi;
            r1_ph   <= n_ph;
            r1_byp  <= i_flags.byp;
            r1_bmag <= i_x[GUARD+DATA_WIDTH-1:GUARD];   // |re| exactly
        end
        if (r1_ready && r1_valid) begin
            r2_mag <= n_mag;
            r2_ph  <= r1_ph;
        end
    end

    assign o_valid = r2_valid;
    assign o_mag   = r2_mag;
    assign o_phase = r2_ph;

    `CRP_ASSERT_NOW(a_phase_range, i_clk, i_rst_n, r2_valid, r2_ph <= PHASE_W'(PHASE_MAX) && r2_ph >= -(PHASE_W'(PHASE_MAX)), "phase outside half turn")
    `CRP_ASSERT_NOW(a_bypass_phase, i_clk, i_rst_n, r1_valid && r1_byp, r1_ph == '0 || r1_ph == PHASE_W'(PHASE_MAX), "real-axis phase not 0 or 180")

endmodule

/* src/complex_rect_to_polar_core.sv */
// Rectangular-to-polar converter. Each item on the slave stream is one complex
// number (real and imaginary parts, two's complement, 11 fraction bits); each
// item on the master stream is its magnitude on the same scale (rounded,
// saturated at all ones) and its phase in degrees with 7 fraction bits, range
// -180..+180, over all four quadrants like atan2. A number on the real axis
// skips the rotations: magnitude |re| exactly, phase 0 or +180; zero gives 0/0.
// Throughput is one item per clock while the master stream is ready. The
// pipeline has one input register (half-plane fold), one CORDIC cell per
// iteration, and two output stages for the split gain multiply and rounding.
// Every stage has its own valid bit, so bubbles close up and the input keeps
// taking items while a result waits at the output until the chain is full.
module complex_rect_to_polar_core import crp_pkg::*; #(
    parameter int ITERATIONS = DEF_ITERATIONS,   // 8..24
    parameter int DATA_WIDTH = DEF_DATA_WIDTH,   // 8..32
    localparam int IN_TW     = ((2 * DATA_WIDTH + 7) / 8) * 8,
    localparam int OUT_TW    = ((DATA_WIDTH + PHASE_W + 7) / 8) * 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // slave stream
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [IN_TW-1:0]     s_axis_tdata,   // [real_part, imag_part], low bits first
    // master stream
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [OUT_TW-1:0]    m_axis_tdata    // [magnitude, phase_degrees], low bits first
);

    `include "complex_rect_to_polar_core_defines.svh"

    // room for the CORDIC gain (~1.65) times sqrt(2), plus the sign
    localparam int XW     = DATA_WIDTH + GUARD + 2;

    logic signed [DATA_WIDTH-1:0] re, im;

    // link k feeds cell k; link ITERATIONS feeds the output stages
    logic                 lk_valid [ITERATIONS+1];
    logic                 lk_ready [ITERATIONS+1];
    logic signed [XW-1:0] lk_x     [ITERATIONS+1];
    logic signed [XW-1:0] lk_y     [ITERATIONS+1];
    logic signed [ZW-1:0] lk_z     [ITERATIONS+1];
    t_flags               lk_flags [ITERATIONS+1];

    logic [DATA_WIDTH-1:0]     mag;
    logic signed [PHASE_W-1:0] phase;

    assign re = s_axis_tdata[DATA_WIDTH-1:0];
    assign im = s_axis_tdata[2*DATA_WIDTH-1:DATA_WIDTH];

    crp_pre #(
        .DATA_WIDTH (DATA_WIDTH),
        .XW         (XW)
    ) u_pre (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_re    (re),
        .i_im    (im),
        .o_valid (lk_valid[0]),
        .i_ready (lk_ready[0]),
        .o_x     (lk_x[0]),
        .o_y     (lk_y[0]),
        .o_z     (lk_z[0]),
        .o_flags (lk_flags[0])
    );

    // the rotation chain: cell k shifts by k and adds/subtracts atan(2^-k)
    for (genvar k = 0; k < ITERATIONS; k++) begin : g_cell
        crp_cell #(
            .XW    (XW),
            .STAGE (k)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (lk_valid[k]),
            .o_ready (lk_ready[k]),
            .i_x     (lk_x[k]),
            .i_y     (lk_y[k]),
            .i_z     (lk_z[k]),
            .i_flags (lk_flags[k]),
            .o_valid (lk_valid[k+1]),
            .i_ready (lk_ready[k+1]),
            .o_x     (lk_x[k+1]),
            .o_y     (lk_y[k+1]),
            .o_z     (lk_z[k+1]),
            .o_flags (lk_flags[k+1])
        );
    end

    crp_post #(
        .DATA_WIDTH (DATA_WIDTH),
        .XW         (XW)
    ) u_post (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (lk_valid[ITERATIONS]),
        .o_ready (lk_ready[ITERATIONS]),
        .i_x     (lk_x[ITERATIONS]),
        .i_z     (lk_z[ITERATIONS]),
        .i_flags (lk_flags[ITERATIONS]),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_mag   (mag),
        .o_phase (phase)
    );

    assign m_axis_tdata = OUT_TW'({phase, mag});

    // a ready sink opens every stage back to the input
    `CRP_ASSERT_NOW(a_ready_path, i_clk, i_rst_n, m_axis_tready, s_axis_tready, "input stalled while output ready")

endmodule

/* tb/testbench.sv */
module testbench;

    localparam int ROTATIONS  = 16;
    localparam int WORD_BITS  = 16;
    localparam int LATENCY    = ROTATIONS + 3;
    localparam int RAND_ITEMS = 1527;

    // fixed-point constants of the converter
    localparam int    FINE_BITS  = 8;            // extra fraction bits in the rotations
    localparam longint HALF_TURN = 188743680;    // 180 deg, Q20
    localparam longint GAIN_K    = 2547003;      // 1/K scaled by 2^22
    localparam int    PHASE_LIM  = 23040;        // 180 deg, Q7
    localparam longint MAG_LIM   = 65535;

    // arctan(2^-n) in degrees, Q20
    localparam longint ARCTAN_DEG [24] = '{
        47185920, 27855475, 14718068, 7471121, 3750058, 1876857, 938658, 469357,
        234682, 117342, 58671, 29335, 14668, 7334, 3667, 1833,
        917, 458, 229, 115, 57, 29, 14, 7
    };

    // first member lands in the upper half of tdata
    typedef struct packed {
        logic signed [15:0] phase;
        logic        [15:0] magnitude;
    } t_polar;

    typedef struct {
        shortint     re;
        shortint     im;
        bit          typed;    // expectation written out in the row
        int unsigned mag;
        int          ph;
    } t_stim_row;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata  = '0;    // [15:0] real_part, [31:16] imag_part
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;          // [15:0] magnitude, [31:16] phase_degrees

    bit     steady = 1'b0;              // no idling on either side while set
    int     mismatch_count = 0;
    t_polar polar_expected [$];

    // directed part: axis points, extremes, the folds near +/-180
    t_stim_row directed_rows [23] = '{
        '{0,      0,      1, 0,     0},
        '{32767,  0,      1, 32767, 0},
        '{-32768, 0,      1, 32768, 23040},
        '{-1,     0,      1, 1,     23040},
        '{1,      0,      1, 1,     0},
        '{-5,     0,      1, 5,     23040},
        '{0,      32767,  0, 0,     0},
        '{0,      -32768, 0, 0,     0},
        '{32767,  32767,  0, 0,     0},
        '{-32768, -32768, 0, 0,     0},
        '{-32768, 32767,  0, 0,     0},
        '{32767,  -32768, 0, 0,     0},
        '{-32768, 1,      0, 0,     0},
        '{-32768, -1,     0, 0,     0},
        '{-1,     1,      0, 0,     0},
        '{-1,     -1,     0, 0,     0},
        '{1,      1,      0, 0,     0},
        '{1,      -1,     0, 0,     0},
        '{0,      1,      0, 0,     0},
        '{0,      -1,     0, 0,     0},
        '{-2048,  2048,   0, 0,     0},
        '{21845,  -21846, 0, 0,     0},
        '{-21846, 21845,  0, 0,     0}
    };

    complex_rect_to_polar_core #(
        .ITERATIONS (ROTATIONS),
        .DATA_WIDTH (WORD_BITS)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #2 i_clk = ~i_clk;

    // magnitude and phase of re + j*im, bit exact
    function automatic t_polar rect_to_polar(input shortint re_in, input shortint im_in);
        longint x, y, z, dx, dy, mag, ph;
        int     n;
        t_polar res;
        if (im_in == 0) begin
            // on the real axis: no rotations
            mag = (re_in < 0) ? -longint'(re_in) : longint'(re_in);
            ph  = (re_in < 0) ? PHASE_LIM : 0;
        end else begin
            x = longint'(re_in) * (longint'(1) << FINE_BITS);
            y = longint'(im_in) * (longint'(1) << FINE_BITS);
            z = 0;
            // left half plane: turn by 180 first
            if (x < 0) begin
                z = (y > 0) ? HALF_TURN : -HALF_TURN;
                x = -x;
                y = -y;
            end
            for (n = 0; n < ROTATIONS; n++) begin
                dx = y >>> n;    // floor shifts
                dy = x >>> n;
                if (y >= 0) begin
                    x = x + dx;
                    y = y - dy;
                    z = z + ARCTAN_DEG[n];
                end else begin
                    x = x - dx;
                    y = y + dy;
                    z = z - ARCTAN_DEG[n];
                end
            end
            if (x < 0) x = 0;
            mag = (x * GAIN_K + (longint'(1) << 29)) >>> 30;
            ph  = (z + 4096) >>> 13;
            if (ph > PHASE_LIM)  ph = PHASE_LIM;
            if (ph < -PHASE_LIM) ph = -PHASE_LIM;
        end
        if (mag > MAG_LIM) mag = MAG_LIM;
        res.magnitude = mag[15:0];
        res.phase     = ph[15:0];
        return res;
    endfunction

    // full-scale or near-zero values, with some plain random ones
    function automatic shortint corner_value();
        case ($urandom_range(5))
            0: return -32768;
            1: return 32767;
            2: return 0;
            3: return -1;
            4: return 1;
            default: return shortint'($urandom);
        endcase
    endfunction

    // offer one item, idling at random first; the expectation is queued on accept
    task automatic send_number(input shortint re, input shortint im, input t_polar want);
        while (!steady && $urandom_range(99) < 35) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {im, re};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        polar_expected.push_back(want);
    endtask

    // result side backpressure
    always @(posedge i_clk) begin
        m_axis_tready <= steady || ($urandom_range(99) >= 35);
    end

    // result checker
    always @(posedge i_clk) begin
        t_polar want;
        t_polar got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata;
            if (polar_expected.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result: mag %0d phase %0d",
                             got.magnitude, got.phase);
            end else begin
                want = polar_expected.pop_front();
                if (got.magnitude !== want.magnitude || got.phase !== want.phase) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: mag exp %0d got %0d, phase exp %0d got %0d",
                                 want.magnitude, got.magnitude, want.phase, got.phase);
                end
            end
        end
    end

    initial begin
        t_polar    want;
        t_stim_row row;
        shortint   re, im;
        int        k;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[r]) begin
            row = directed_rows[r];
            if (row.typed) begin
                want.magnitude = row.mag[15:0];
                want.phase     = row.ph[15:0];
            end else begin
                want = rect_to_polar(row.re, row.im);
            end
            send_number(row.re, row.im, want);
        end

        for (k = 0; k < RAND_ITEMS; k++) begin
            steady <= (k >= 700 && k < 1000);
            case ($urandom_range(9))
                0, 1, 2, 3, 4: begin
                    re = shortint'($urandom);
                    im = shortint'($urandom);
                end
                5: begin
                    // tiny numbers, where rounding dominates
                    re = shortint'($urandom_range(63)) - 16'sd32;
                    im = shortint'($urandom_range(63)) - 16'sd32;
                end
                6: begin
                    re = shortint'($urandom);
                    im = 0;
                end
                7: begin
                    // close to the negative real axis: phase near the clamp
                    re = -shortint'($urandom_range(32768, 1));
                    im = shortint'($urandom_range(7)) - 16'sd4;
                end
                default: begin
                    re = corner_value();
                    im = corner_value();
                end
            endcase
            send_number(re, im, rect_to_polar(re, im));
        end
        s_axis_tvalid <= 1'b0;
        steady        <= 1'b0;

        while (polar_expected.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 20) @(posedge i_clk);

        if (mismatch_count == 0 && polar_expected.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // run limit, far above the slowest legal run
    initial begin
        #800000;
        $display("== FAIL ==");
        $finish;
    end

endmodule

/* sim.f */
+incdir+src
src/crp_pkg.sv
src/crp_pre.sv
src/crp_cell.sv
src/crp_post.sv
src/complex_rect_to_polar_core.sv
tb/testbench.sv
